/* rtl/core/rsst_pkg.sv */
// Shared constants for the range-sum segment tree: field widths, item
// function codes and configuration register indexes. No dependencies.
package rsst_pkg;

  // Fixed widths of the item fields.
  localparam int INDEX_W = 10;
  localparam int DATA_W  = 32;

  // Item function codes.
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  // Configuration address: one 32-bit register at byte address 0.
  localparam int   CFG_AW       = 3;
  localparam logic REG_IDENTITY = 1'b0;

endpackage

/* rtl/core/rsst_node_ram.sv */
// Node sum store of the segment tree: single write port, single read port,
// registered read data. No dependencies.
module rsst_node_ram #(
  parameter  int DEPTH = 2048,
  parameter  int DW    = 32,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* rtl/core/range_sum_segment_tree.sv */
// Range-sum segment tree, top level: item channels, configuration port,
// sequencer and shared adder. Depends on rsst_pkg and rsst_node_ram.
//
//   Input channel (in_valid / in_stall) takes one item at a time; func
//   selects a write of one entry or a query of an inclusive range sum.
//   Output channel (out_valid / out_stall) carries one range_total per
//   query; writes give no result. One RAM read port and one adder serve
//   both the leaf-to-root update and the query accumulation.
//   A write stores the leaf, then climbs the tree level by level: at each
//   level the sibling is read, then added and the sum stored in the
//   parent. A query is accepted, then makes up to log2(ENTRIES)+1 passes
//   up the tree, each a low-side step and a high-side step, closes the
//   walk and hands off the result. An empty or out-of-range query returns
//   identity_value without walking the tree. in_stall stays high meanwhile.
//   After reset the block clears all 2*ENTRIES nodes, one per cycle, with
//   in_stall high until the last node is cleared; the APB port works
//   throughout. identity_value resets to 0.
//   A finished result sits in the output register; while the receiver
//   stalls, the next item is still accepted and worked, and only its
//   hand-off waits for the register to drain.
module range_sum_segment_tree #(
  parameter int ENTRIES     = 1024,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // input channel
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_func,
  input  logic [rsst_pkg::INDEX_W-1:0] in_entry_index,
  input  logic signed [rsst_pkg::DATA_W-1:0] in_entry_value,
  input  logic [rsst_pkg::INDEX_W-1:0] in_range_first,
  input  logic [rsst_pkg::INDEX_W-1:0] in_range_last,
  // result channel
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [rsst_pkg::DATA_W-1:0] out_range_total,
  // configuration port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [rsst_pkg::CFG_AW-1:0] paddr,
  input  logic [rsst_pkg::DATA_W-1:0] pwdata,
  output logic [rsst_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);

  import rsst_pkg::*;

  localparam int NODE_COUNT = 2 * ENTRIES;
  localparam int AW = $clog2(NODE_COUNT);       // node address
  localparam int NW = $clog2(NODE_COUNT + 1);   // query bound, reaches NODE_COUNT
  localparam int VW = VALUE_WIDTH;
  localparam logic [31:0] ENTRIES_W = 32'(ENTRIES);
  localparam logic [AW-1:0] LAST_NODE = AW'(NODE_COUNT - 1);
  localparam logic [AW-1:0] ROOT_NODE = AW'(1);

  // sequencer states
  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_WRD  = 3'd2;
  localparam logic [2:0] S_WADD = 3'd3;
  localparam logic [2:0] S_QLO  = 3'd4;
  localparam logic [2:0] S_QHI  = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  // 32-bit port value to stored width: sign-extend or keep low bits.
  function automatic logic [VW-1:0] from32(input logic [31:0] x);
    logic [63:0] e;
    e = 64'(signed'(x));
    return e[VW-1:0];
  endfunction

  // Stored value to 32-bit port value: sign-extend or keep low bits.
  function automatic logic [31:0] to32(input logic [VW-1:0] v);
    logic signed [VW-1:0] s;
    logic [63:0] e;
    s = v;
    e = 64'(s);
    return e[31:0];
  endfunction

  logic [2:0]    state_r, state_nxt;
  logic [AW-1:0] clr_r, clr_nxt;
  logic [AW-1:0] p_r, p_nxt;
  logic [NW-1:0] lo_r, lo_nxt;
  logic [NW-1:0] hi_r, hi_nxt;
  logic          pend_r, pend_nxt;
  logic [VW-1:0] acc_r, acc_nxt;
  logic [VW-1:0] id_r;
  logic          out_valid_r, out_valid_nxt;
  logic [31:0]   out_total_r;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [VW-1:0] ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [VW-1:0] ram_rdata;

  logic [VW-1:0] sum;
  logic          accept;
  logic [31:0]   first_w, last_w, last_c;
  logic [AW-1:0] p_up;
  logic [NW-1:0] hi_m1;
  logic          cfg_wr;

  rsst_node_ram #(
    .DEPTH(NODE_COUNT),
    .DW   (VW)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // The one adder: running value plus the word just read.
  assign sum = acc_r + ram_rdata;

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;

  assign first_w = 32'(in_range_first);
  assign last_w  = 32'(in_range_last);
  assign last_c  = (last_w >= ENTRIES_W) ? (ENTRIES_W - 32'd1) : last_w;
  assign p_up    = {1'b0, p_r[AW-1:1]};
  assign hi_m1   = hi_r - NW'(1);

  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    p_nxt     = p_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    pend_nxt  = 1'b0;
    acc_nxt   = acc_r;
    ram_we    = 1'b0;
    ram_waddr = p_up;
    ram_wdata = sum;
    ram_raddr = lo_r[AW-1:0];
    out_valid_nxt = out_valid_r && out_stall;

    case (state_r)
      S_CLR: begin
        // zero one node per cycle
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = '0;
        clr_nxt   = clr_r + AW'(1);
        if (clr_r == LAST_NODE) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          if (in_func == FUNC_WRITE) begin
            // drop writes past the array
            if (32'(in_entry_index) < ENTRIES_W) begin
              ram_we    = 1'b1;
              ram_waddr = AW'(ENTRIES_W + 32'(in_entry_index));
              ram_wdata = from32(in_entry_value);
              acc_nxt   = from32(in_entry_value);
              p_nxt     = AW'(ENTRIES_W + 32'(in_entry_index));
              state_nxt = S_WRD;
            end
          end else if (first_w >= ENTRIES_W || in_range_first > in_range_last) begin
            acc_nxt   = id_r;
            state_nxt = S_DONE;
          end else begin
            acc_nxt   = '0;
            lo_nxt    = NW'(first_w + ENTRIES_W);
            hi_nxt    = NW'(last_c + ENTRIES_W + 32'd1);
            state_nxt = S_QLO;
          end
        end
      end
      S_WRD: begin
        // fetch the sibling of the node just stored
        ram_raddr = p_r ^ AW'(1);
        state_nxt = S_WADD;
      end
      S_WADD: begin
        ram_we    = 1'b1;
        ram_waddr = p_up;
        ram_wdata = sum;
        acc_nxt   = sum;
        p_nxt     = p_up;
        state_nxt = (p_up == ROOT_NODE) ? S_IDLE : S_WRD;
      end
      S_QLO: begin
        if (pend_r) begin
          acc_nxt = sum;
        end
        if (lo_r < hi_r) begin
          if (lo_r[0]) begin
            ram_raddr = lo_r[AW-1:0];
            lo_nxt    = lo_r + NW'(1);
            pend_nxt  = 1'b1;
          end
          state_nxt = S_QHI;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_QHI: begin
        if (pend_r) begin
          acc_nxt = sum;
        end
        if (hi_r[0]) begin
          ram_raddr = hi_m1[AW-1:0];
          pend_nxt  = 1'b1;
        end
        // climb one level; odd hi minus one shifts to the same parent
        lo_nxt    = lo_r >> 1;
        hi_nxt    = hi_r >> 1;
        state_nxt = S_QLO;
      end
      S_DONE: begin
        // hold until the output register is free
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p_r   <= p_nxt;
    lo_r  <= lo_nxt;
    hi_r  <= hi_nxt;
    acc_r <= acc_nxt;
    if (state_r == S_DONE && (!out_valid_r || !out_stall)) begin
      out_total_r <= to32(acc_r);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_range_total = out_total_r;

  // Configuration: identity_value at byte address 0.
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      id_r <= '0;
    end else if (cfg_wr && paddr[2] == REG_IDENTITY) begin
      id_r <= from32(pwdata);
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_IDENTITY) ? to32(id_r) : '0;

endmodule
